// ----- src/bkd_pkg.sv -----
// shared constants, types and helpers for the base-k digit converter
package bkd_pkg;

    localparam int unsigned MAX_DIGITS_DEF = 64;
    localparam int unsigned VALUE_BITS_DEF = 63;

    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_BASE    = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;

    // status of the serial divider toward the sequencer
    typedef struct packed {
        logic               done;
        logic               nonzero;
        logic [DIGIT_W-1:0] digit;
    } div_status_t;

    function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] r);
        logic [DIGIT_W-1:0] k;
        k = r;
        if (r < RADIX_MIN) begin
            k = RADIX_MIN;
        end
        else if (r > RADIX_MAX) begin
            k = RADIX_MAX;
        end
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + {1'b0, d};
        end
        else begin
            c = CHAR_A + {1'b0, d} - {1'b0, DEC_BASE};
        end
        return c;
    endfunction

endpackage

// ----- src/bkd_divider.sv -----
// bit-serial long division of the working value by the radix, one quotient bit per cycle
module bkd_divider #(
    parameter int unsigned VALUE_BITS = bkd_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          again,
    input  logic [bkd_pkg::DIGIT_W-1:0]   k,
    input  logic [VALUE_BITS-1:0]         value,
    output bkd_pkg::div_status_t          status
);
    import bkd_pkg::*;

    localparam int unsigned BW = $clog2(VALUE_BITS);

    logic                  busy_reg;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic                  nz_reg;
    logic [BW-1:0]         bit_reg;

    logic [DIGIT_W:0] trial;
    logic [DIGIT_W:0] diff;
    logic             ge;
    logic             last_bit;

    // shift the next dividend bit into the partial remainder
    assign trial    = {rem_reg, q_reg[VALUE_BITS-1]};
    assign ge       = (trial >= {1'b0, k});
    assign diff     = trial - {1'b0, k};
    assign rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    assign q_next   = {q_reg[VALUE_BITS-2:0], ge};
    assign last_bit = (bit_reg == '0);

    assign status.done    = busy_reg && last_bit;
    assign status.nonzero = nz_reg | ge;
    assign status.digit   = rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            nz_reg   <= 1'b0;
            bit_reg  <= '0;
        end
        else if (load) begin
            busy_reg <= 1'b1;
            nz_reg   <= 1'b0;
            bit_reg  <= BW'(VALUE_BITS - 1);
        end
        else if (busy_reg) begin
            if (last_bit) begin
                // restart on the quotient just formed, or stop
                busy_reg <= again;
                nz_reg   <= 1'b0;
                bit_reg  <= BW'(VALUE_BITS - 1);
            end
            else begin
                nz_reg  <= nz_reg | ge;
                bit_reg <= bit_reg - BW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            q_reg   <= value;
            rem_reg <= '0;
        end
        else if (busy_reg) begin
            q_reg   <= q_next;
            rem_reg <= (last_bit) ? '0 : rem_next;
        end
    end

endmodule

// ----- src/binary_to_base_k_digits_core.sv -----
// binary to base-k ascii digit converter, top level
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  input    | in_valid / in_stall      | value
//  output   | out_valid / out_stall    | digit_char, last
//  config   | cfg_valid / cfg_ready    | cfg_data (radix)
//
// a number of n digits is formed by n rounds of serial division, one quotient
// bit per cycle, then each character takes a digit store read and an output load
// one word is taken at a time; in_stall is high from acceptance until the last
// character is loaded into the output register
// reset: radix 10, no word in flight, output empty
// a stalled output only delays character loading; the division is not affected
module binary_to_base_k_digits_core #(
    parameter int unsigned MAX_DIGITS = bkd_pkg::MAX_DIGITS_DEF,
    parameter int unsigned VALUE_BITS = bkd_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [VALUE_BITS-1:0]        value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bkd_pkg::CHAR_W-1:0]   digit_char,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bkd_pkg::DIGIT_W-1:0]  cfg_data
);
    import bkd_pkg::*;

    localparam int unsigned AW = $clog2(MAX_DIGITS);
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DIGIT_W-1:0] radix_reg;
    logic [DIGIT_W-1:0] k_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;

    logic [DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic                out_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;

    logic        accept;
    logic        load_out;
    logic        again;
    logic        mem_we;
    div_status_t div_stat;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign digit_char = out_char_reg;
    assign last       = out_last_reg;

    assign load_out = (state_reg == S_WR) && (!out_valid_reg || !out_stall);
    assign mem_we   = (state_reg == S_DIV) && div_stat.done;
    // keep dividing while the quotient is nonzero and the store has room
    assign again    = mem_we && div_stat.nonzero && (cnt_reg != CW'(MAX_DIGITS - 1));

    bkd_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .again  (again),
        .k      (k_reg),
        .value  (value),
        .status (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV: begin
                if (again) begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (mem_we) begin
                    idx_next   = cnt_reg[AW-1:0];
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                if (load_out) begin
                    if (idx_reg == '0) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            radix_reg     <= RADIX_RESET;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_data;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // digit store: least significant digit at entry 0
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[cnt_reg[AW-1:0]] <= div_stat.digit;
        end
        if (state_reg == S_RD) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            k_reg <= clamp_radix(radix_reg);
        end
        if (load_out) begin
            out_char_reg <= digit_to_ascii(rd_data_reg);
            out_last_reg <= (idx_reg == '0);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DIV))
        else $error("accepted word did not start division");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider finished outside division state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= CW'(MAX_DIGITS - 1)))
        else $error("digit count ran past the store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (idx_reg == '0)) |=> (state_reg == S_IDLE) && out_last_reg)
        else $error("final character did not end the word");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && !div_stat.done) |=> $stable(k_reg))
        else $error("radix changed during division");

endmodule

// ----- tb/bkd_checker.sv -----
// checker for the base-k digit converter: predicts the ascii digits and compares them
module bkd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [bkd_pkg::VALUE_BITS_DEF-1:0] value,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [bkd_pkg::CHAR_W-1:0]   digit_char,
    input  logic                         last,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [bkd_pkg::DIGIT_W-1:0]  cfg_data,
    output int                           mismatches,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bkd_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    char_word_t         expected_chars[$];
    logic [DIGIT_W-1:0] radix_reg = RADIX_RESET;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // queue the characters of v in base r clamped to the radix range, most significant first
    function automatic void queue_digits(input logic [VALUE_BITS_DEF-1:0] v,
                                         input logic [DIGIT_W-1:0] r);
        logic [63:0]        rest;
        logic [63:0]        k;
        logic [DIGIT_W-1:0] digits[MAX_DIGITS_DEF];
        logic [DIGIT_W-1:0] d;
        int                 n;
        char_word_t         w;
        k = {58'd0, r};
        if (r < RADIX_MIN) begin
            k = {58'd0, RADIX_MIN};
        end
        else if (r > RADIX_MAX) begin
            k = {58'd0, RADIX_MAX};
        end
        rest = {1'b0, v};
        n = 0;
        if (rest == 64'd0) begin
            digits[0] = '0;
            n = 1;
        end
        while (rest != 64'd0 && n < MAX_DIGITS_DEF) begin
            digits[n] = DIGIT_W'(rest % k);
            rest = rest / k;
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            d = digits[i];
            if (d < DEC_BASE) begin
                w.ch = CHAR_ZERO + {1'b0, d};
            end
            else begin
                w.ch = CHAR_A + {1'b0, d} - {1'b0, DEC_BASE};
            end
            w.last = (i == 0);
            expected_chars.insert(expected_chars.size(), w);
        end
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk) begin
        char_word_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected char %0d last %0d, nothing pending",
                                            digit_char, last));
                end
                else begin
                    want = expected_chars.pop_front();
                    if (want.ch !== digit_char || want.last !== last) begin
                        note_mismatch($sformatf(
                            "mismatch: expected char %0d last %0d, got char %0d last %0d",
                            want.ch, want.last, digit_char, last));
                    end
                end
            end
            // a word taken at this edge still sees the radix from before a write here
            if (in_valid && !in_stall) begin
                queue_digits(value, radix_reg);
            end
            if (cfg_valid && cfg_ready) begin
                radix_reg = cfg_data;
            end
            pending = expected_chars.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// top-level testbench for the base-k digit converter: stimulus, idling and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bkd_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int STALL_LIMIT = 30000;
    localparam int LONG_HOLD   = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [VB-1:0]       value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHAR_W-1:0]   digit_char;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [DIGIT_W-1:0]  cfg_data = '0;

    int   mismatches;
    int   pending;
    int   in_idle_pct = 0;
    int   out_idle_pct = 0;
    int   quiet_cycles = 0;
    int   hold_left = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;

    always #5 clk = ~clk;

    binary_to_base_k_digits_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    bkd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver: random stall, plus one long hold-off so the converter backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // watchdog on cycles in which no word moves on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_number(input logic [VB-1:0] v);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // lower the input, then wait until every expected character has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_radix(input logic [DIGIT_W-1:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VB-1:0] random_number();
        int          kind;
        int          w;
        logic [63:0] raw;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            return '0;
        end
        if (kind < 20) begin
            return VB'($urandom_range(0, 40));
        end
        if (kind < 30) begin
            raw = '1;
            raw[$urandom_range(0, VB - 1)] = 1'b0;
            return raw[VB-1:0];
        end
        // random bit length keeps the serial division short on average
        w = $urandom_range(1, VB);
        raw = raw & ((64'd1 << w) - 64'd1);
        return raw[VB-1:0];
    endfunction

    initial begin
        logic [VB-1:0] all_ones;
        all_ones = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset radix, then the radix extremes, clamping and radix 16
        send_number('0);
        send_number(VB'(1));
        send_number(VB'(9));
        send_number(all_ones);
        send_number(VB'(1) << (VB - 1));
        set_radix(RADIX_MAX);
        send_number(VB'(35));
        send_number(VB'(36));
        send_number(all_ones);
        send_number('0);
        set_radix(RADIX_MIN);
        send_number(all_ones);
        send_number(VB'(1));
        send_number('0);
        set_radix(6'd0);
        send_number(VB'(5));
        set_radix(6'd1);
        send_number(VB'(6));
        set_radix(6'd37);
        send_number(VB'(35));
        set_radix(6'd63);
        send_number(all_ones);
        set_radix(6'd16);
        send_number(VB'(64'hFEDC_BA98_7654_3210));
        send_number(VB'(255));

        for (int mode = 0; mode < 3; mode++) begin
            in_idle_pct  = (mode == 0) ? 14 : (mode == 1) ? 48 : 0;
            out_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 14 : 0;
            for (int i = 0; i < 60; i++) begin
                if (i % 20 == 0) begin
                    set_radix(DIGIT_W'($urandom_range(0, 63)));
                end
                if (mode == 0 && i == 5) begin
                    hold_go <= 1'b1;
                end
                send_number(random_number());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bkd_pkg.sv
src/bkd_divider.sv
src/binary_to_base_k_digits_core.sv
tb/bkd_checker.sv
tb/tb.sv
